FILE: rtl/core/per_source_connection_limiter_unit_defines.svh
// ----------------------------------------------------------------------------
// per_source_connection_limiter_unit_defines
// assertion macros used by the limiter checker file
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_CONNECTION_LIMITER_UNIT_DEFINES_SVH
`define PER_SOURCE_CONNECTION_LIMITER_UNIT_DEFINES_SVH

// property checked outside reset
`define PSL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("limiter property failed");

// property checked on every edge, reset included
`define PSL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("limiter reset property failed");

`endif

FILE: rtl/core/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg
// shared types, constants and helpers of the per-source connection limiter
// ----------------------------------------------------------------------------
package psl_pkg;

    // table size, one cell per entry
    localparam int TABLE_ENTRIES = 64;

    // request kinds
    typedef enum logic [1:0] {
        KIND_CHECK  = 2'd0,
        KIND_CONN   = 2'd1,
        KIND_FAIL   = 2'd2,
        KIND_LOOKUP = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_CONN   = 2'd0;
    localparam logic [1:0] CFG_WINDOW_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_FAIL   = 2'd2;
    localparam logic [1:0] CFG_BAN_LEN    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ip_address;
        logic [31:0] now_time;
    } t_in;

    typedef struct packed {
        logic        allowed;
        logic        found;
        logic        banned;
        logic        table_full;
        logic [15:0] connection_count;
        logic [15:0] failure_count;
    } t_out;

    typedef struct packed {
        logic [15:0] max_connections;
        logic [31:0] window_length;
        logic [15:0] fail_limit;
        logic [31:0] ban_length;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        max_connections: 16'd10,
        window_length:   32'd60000,
        fail_limit:      16'd5,
        ban_length:      32'd300000
    };

    // request token walking the cell chain
    typedef struct packed {
        logic valid;
        logic done;
        t_in  req;
        t_out res;
    } t_token;

    // ban window test on wrapping time
    function automatic logic is_banned(input logic [31:0] ban_end,
                                       input logic [31:0] now,
                                       input logic [31:0] ban_len);
        logic [31:0] r;
        r = ban_end - now;
        return (r != 32'd0) && (r <= ban_len);
    endfunction

    // saturating increment of a 16-bit count
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

FILE: rtl/core/per_source_connection_limiter_unit.sv
// The response register takes each result as its token leaves the last cell.
// Throughput: one request per cycle while the response side takes results.
// Each request walks the chain of TABLE_ENTRIES entry cells, one cell per
// cycle, and the whole chain holds while the response register is stalled.
// Reset (synchronous, active low) empties the table and the chain and loads
// the default configuration; no clearing pass is needed.
// ----------------------------------------------------------------------------
// per_source_connection_limiter_unit
// fixed-window connection limiter with ban, keyed by IPv4 source address
// ----------------------------------------------------------------------------
module per_source_connection_limiter_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  psl_pkg::t_in  i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output psl_pkg::t_out o_rsp,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    psl_pkg::t_cfg   r_cfg;
    psl_pkg::t_token w_tok [0:psl_pkg::TABLE_ENTRIES];
    psl_pkg::t_token last;
    psl_pkg::t_out   n_rsp;
    psl_pkg::t_out   r_rsp;
    logic            r_rsp_valid;
    logic            adv;

    // whole chain moves when the response register can take a result
    assign adv         = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= psl_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psl_pkg::CFG_MAX_CONN:   r_cfg.max_connections <= i_cfg_data[15:0];
                psl_pkg::CFG_WINDOW_LEN: r_cfg.window_length   <= i_cfg_data;
                psl_pkg::CFG_MAX_FAIL:   r_cfg.fail_limit      <= i_cfg_data[15:0];
                psl_pkg::CFG_BAN_LEN:    r_cfg.ban_length      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // new request token entering the first cell
    always_comb begin
        w_tok[0].valid = i_req_valid;
        w_tok[0].done  = 1'b0;
        w_tok[0].req   = i_req;
        w_tok[0].res   = '0;
    end

    // chain of entry cells
    for (genvar g = 0; g < psl_pkg::TABLE_ENTRIES; g++) begin : g_cell
        psl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cfg   (r_cfg),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // requests that fell off the end: unknown key, maybe a full table
    assign last = w_tok[psl_pkg::TABLE_ENTRIES];

    always_comb begin
        n_rsp = last.res;
        if (!last.done) begin
            n_rsp            = '0;
            n_rsp.allowed    = last.req.kind == psl_pkg::KIND_CHECK;
            n_rsp.table_full = last.req.kind inside {psl_pkg::KIND_CONN, psl_pkg::KIND_FAIL};
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (adv) begin
            r_rsp_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

FILE: rtl/core/psl_cell.sv
// ----------------------------------------------------------------------------
// psl_cell
// one table entry plus one token stage; serves the request on key hit, or
// finishes it at the first free slot, where a CONN or FAIL takes the slot
// ----------------------------------------------------------------------------
module psl_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  psl_pkg::t_cfg    i_cfg,
    input  psl_pkg::t_token  i_tok,
    output psl_pkg::t_token  o_tok
);

    logic            r_ent_vld, n_ent_vld;
    logic [31:0]     r_key, n_key;
    logic [15:0]     r_conn, n_conn;
    logic [15:0]     r_fail, n_fail;
    logic [31:0]     r_wstart, n_wstart;
    logic [31:0]     r_banend, n_banend;
    psl_pkg::t_token r_tok, n_tok;

    logic            live;
    logic            hit;
    logic            empty;
    logic            banned_now;
    logic            elapsed;
    logic [15:0]     conn_inc;
    logic [15:0]     fail_inc;
    logic [31:0]     ban_stop;

    // entries fill from the low end and are never freed, so the first
    // free cell proves the key is absent further down
    always_comb begin
        live       = i_tok.valid && !i_tok.done;
        hit        = live && r_ent_vld && (r_key == i_tok.req.ip_address);
        empty      = live && !r_ent_vld;
        banned_now = psl_pkg::is_banned(r_banend, i_tok.req.now_time, i_cfg.ban_length);
        elapsed    = (i_tok.req.now_time - r_wstart) > i_cfg.window_length;
        conn_inc   = psl_pkg::sat_inc(r_conn);
        fail_inc   = psl_pkg::sat_inc(r_fail);
        ban_stop   = i_tok.req.now_time + i_cfg.ban_length;

        n_tok     = i_tok;
        n_ent_vld = r_ent_vld;
        n_key     = r_key;
        n_conn    = r_conn;
        n_fail    = r_fail;
        n_wstart  = r_wstart;
        n_banend  = r_banend;

        if (hit) begin
            // update an existing entry
            n_tok.done       = 1'b1;
            n_tok.res        = '0;
            n_tok.res.found  = 1'b1;
            n_tok.res.banned = banned_now;
            case (i_tok.req.kind)
                psl_pkg::KIND_CHECK: begin
                    if (banned_now) begin
                        n_tok.res.allowed = 1'b0;
                    end else if (elapsed) begin
                        n_conn            = 16'd0;
                        n_wstart          = i_tok.req.now_time;
                        n_tok.res.allowed = 1'b1;
                    end else begin
                        n_tok.res.allowed = r_conn < i_cfg.max_connections;
                    end
                end
                psl_pkg::KIND_CONN: begin
                    n_conn = conn_inc;
                end
                psl_pkg::KIND_FAIL: begin
                    n_fail = fail_inc;
                    if (fail_inc >= i_cfg.fail_limit) begin
                        n_banend         = ban_stop;
                        n_tok.res.banned = i_cfg.ban_length != 32'd0;
                    end
                end
                default: begin
                end
            endcase
            n_tok.res.connection_count = n_conn;
            n_tok.res.failure_count    = n_fail;
        end else if (empty) begin
            // key absent: record kinds insert here, others finish empty
            n_tok.done = 1'b1;
            n_tok.res  = '0;
            case (i_tok.req.kind)
                psl_pkg::KIND_CHECK: begin
                    n_tok.res.allowed = 1'b1;
                end
                psl_pkg::KIND_CONN: begin
                    n_ent_vld                  = 1'b1;
                    n_key                      = i_tok.req.ip_address;
                    n_conn                     = 16'd1;
                    n_fail                     = 16'd0;
                    n_wstart                   = i_tok.req.now_time;
                    n_banend                   = i_tok.req.now_time;
                    n_tok.res.connection_count = 16'd1;
                end
                psl_pkg::KIND_FAIL: begin
                    n_ent_vld               = 1'b1;
                    n_key                   = i_tok.req.ip_address;
                    n_conn                  = 16'd0;
                    n_fail                  = 16'd1;
                    n_wstart                = i_tok.req.now_time;
                    n_banend                = i_tok.req.now_time;
                    n_tok.res.failure_count = 16'd1;
                    if (i_cfg.fail_limit <= 16'd1) begin
                        n_banend         = ban_stop;
                        n_tok.res.banned = i_cfg.ban_length != 32'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control state and token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld   <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_ent_vld <= n_ent_vld;
            r_tok     <= n_tok;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key    <= n_key;
            r_conn   <= n_conn;
            r_fail   <= n_fail;
            r_wstart <= n_wstart;
            r_banend <= n_banend;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/core/psl_checker.sv
// ----------------------------------------------------------------------------
// psl_checker
// port-level properties of the connection limiter, bound to the top level
// ----------------------------------------------------------------------------
`include "per_source_connection_limiter_unit_defines.svh"

module psl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_rsp_valid,
    input logic          i_rsp_ready,
    input psl_pkg::t_out o_rsp
);

    logic full_rsp;
    logic no_counts;

    // dropped insert and its reported counts
    assign full_rsp  = o_rsp_valid && o_rsp.table_full;
    assign no_counts = (o_rsp.connection_count == 16'd0) && (o_rsp.failure_count == 16'd0);

    // no response straight out of reset
    `PSL_ASSERT_ALWAYS(a_rst_no_rsp, !i_rst_n |=> !o_rsp_valid)

    // a stalled response stays up
    `PSL_ASSERT(a_rsp_hold, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid)

    // an admitted address is never under a ban
    `PSL_ASSERT(a_allow_not_banned, o_rsp_valid && o_rsp.allowed |-> !o_rsp.banned)

    // a dropped insert reports an unknown address with empty counts
    `PSL_ASSERT(a_full_empty, full_rsp |-> !o_rsp.found && !o_rsp.allowed && no_counts)

endmodule

bind per_source_connection_limiter_unit psl_checker u_psl_checker (.*);

FILE: verif/per_source_connection_limiter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_connection_limiter_unit_test
// self-checking bench: a directed table, two bursts and then constrained-random traffic
// over several limit settings. Each response is compared field by field with an
// in-order queue of verdicts, given by the directed table or from a behavioral copy of the address table.
// ----------------------------------------------------------------------------
module per_source_connection_limiter_unit_test;

    localparam int POOL_KEYS  = 72;
    localparam int QUIET_MAX  = 4000;
    localparam int SAT_ITEMS  = 16;
    localparam int MAX_PRINTS = 40;

    // one row of the directed table
    typedef struct packed {
        psl_pkg::t_in  req;
        logic          exp_given;
        psl_pkg::t_out exp_rsp;
    } t_dir_row;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_req_valid = 1'b0;
    psl_pkg::t_in  i_req       = '0;
    logic          i_rsp_ready = 1'b0;
    logic          i_cfg_we    = 1'b0;
    logic [1:0]    i_cfg_idx   = psl_pkg::CFG_MAX_CONN;
    logic [31:0]   i_cfg_data  = '0;
    logic          o_req_ready;
    logic          o_rsp_valid;
    psl_pkg::t_out o_rsp;

    // behavioral copy of the table and limits
    psl_pkg::t_cfg lim_cfg = psl_pkg::CFG_RESET;
    logic          slot_used [psl_pkg::TABLE_ENTRIES];
    logic [31:0]   slot_key  [psl_pkg::TABLE_ENTRIES];
    logic [15:0]   conn_cnt  [psl_pkg::TABLE_ENTRIES];
    logic [15:0]   fail_cnt  [psl_pkg::TABLE_ENTRIES];
    logic [31:0]   win_start [psl_pkg::TABLE_ENTRIES];
    logic [31:0]   ban_until [psl_pkg::TABLE_ENTRIES];

    psl_pkg::t_out verdict_q [$];
    t_dir_row      dir_table [$];
    logic [31:0]   key_pool  [POOL_KEYS];
    logic [31:0]   tick_now;
    int            err_count = 0;
    int            rsp_count = 0;
    int            quiet_cycles = 0;

    per_source_connection_limiter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic int find_key(input logic [31:0] key);
        for (int i = 0; i < psl_pkg::TABLE_ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < psl_pkg::TABLE_ENTRIES; i++)
            if (!slot_used[i])
                return i;
        return -1;
    endfunction

    // ban holds while the remaining time is in (0, ban_length]
    function automatic logic ban_active(input int slot, input logic [31:0] now);
        logic [31:0] left;
        left = ban_until[slot] - now;
        return (left != 32'd0) && (left <= lim_cfg.ban_length);
    endfunction

    // verdict for one request, updating the table copy
    function automatic psl_pkg::t_out predict_verdict(input psl_pkg::t_in r);
        psl_pkg::t_out v;
        int            slot;
        logic          hit;
        logic [31:0]   age;
        v    = '0;
        slot = find_key(r.ip_address);
        hit  = (slot >= 0);
        case (r.kind)
            psl_pkg::KIND_CHECK: begin
                if (!hit) begin
                    v.allowed = 1'b1;
                end else if (ban_active(slot, r.now_time)) begin
                    v.allowed = 1'b0;
                end else begin
                    age = r.now_time - win_start[slot];
                    if (age > lim_cfg.window_length) begin
                        conn_cnt[slot]  = 16'd0;
                        win_start[slot] = r.now_time;
                        v.allowed       = 1'b1;
                    end else begin
                        v.allowed = (conn_cnt[slot] < lim_cfg.max_connections);
                    end
                end
            end
            psl_pkg::KIND_CONN, psl_pkg::KIND_FAIL: begin
                if (!hit) begin
                    slot = first_free();
                    if (slot < 0) begin
                        v.table_full = 1'b1;
                    end else begin
                        slot_used[slot] = 1'b1;
                        slot_key[slot]  = r.ip_address;
                        conn_cnt[slot]  = 16'd0;
                        fail_cnt[slot]  = 16'd0;
                        win_start[slot] = r.now_time;
                        ban_until[slot] = r.now_time;
                    end
                end
                if (slot >= 0) begin
                    if (r.kind == psl_pkg::KIND_CONN) begin
                        if (conn_cnt[slot] != 16'hFFFF)
                            conn_cnt[slot] = conn_cnt[slot] + 16'd1;
                    end else begin
                        if (fail_cnt[slot] != 16'hFFFF)
                            fail_cnt[slot] = fail_cnt[slot] + 16'd1;
                        if (fail_cnt[slot] >= lim_cfg.fail_limit)
                            ban_until[slot] = r.now_time + lim_cfg.ban_length;
                    end
                end
            end
            default: ;
        endcase
        v.found = hit;
        if (slot >= 0) begin
            v.banned           = ban_active(slot, r.now_time);
            v.connection_count = conn_cnt[slot];
            v.failure_count    = fail_cnt[slot];
        end
        return v;
    endfunction

    // ---------------------------------------------------------------- helpers

    function automatic psl_pkg::t_out rsp_of(input int a, input int f, input int b,
                                             input int full, input int c, input int fc);
        psl_pkg::t_out v;
        v.allowed          = a[0];
        v.found            = f[0];
        v.banned           = b[0];
        v.table_full       = full[0];
        v.connection_count = c[15:0];
        v.failure_count    = fc[15:0];
        return v;
    endfunction

    function automatic t_dir_row row(input psl_pkg::t_kind kind, input logic [31:0] ip,
                                     input logic [31:0] now, input logic given,
                                     input psl_pkg::t_out rsp);
        t_dir_row d;
        d.req.kind       = kind;
        d.req.ip_address = ip;
        d.req.now_time   = now;
        d.exp_given      = given;
        d.exp_rsp        = rsp;
        return d;
    endfunction

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("response %0d %s got %0h want %0h",
                                   rsp_count, name, got, want));
    endtask

    // ---------------------------------------------------------------- drivers

    // one request, with an optional idle gap in front
    task automatic send_req(input psl_pkg::t_in r, input logic may_idle, input logic given,
                            input psl_pkg::t_out rsp);
        int            gap;
        int            p;
        psl_pkg::t_out v;
        gap = 0;
        if (may_idle) begin
            p = $urandom_range(0, 99);
            if (p < 50)      gap = 0;
            else if (p < 90) gap = $urandom_range(1, 3);
            else if (p < 98) gap = $urandom_range(4, 10);
            else             gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        v = predict_verdict(r);
        verdict_q.push_back(given ? rsp : v);
    endtask

    // stop sending and let every outstanding response come back
    task automatic drain_verdicts();
        i_req_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            psl_pkg::CFG_MAX_CONN:   lim_cfg.max_connections = data[15:0];
            psl_pkg::CFG_WINDOW_LEN: lim_cfg.window_length   = data;
            psl_pkg::CFG_MAX_FAIL:   lim_cfg.fail_limit      = data[15:0];
            psl_pkg::CFG_BAN_LEN:    lim_cfg.ban_length      = data;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [15:0] max_conn, input logic [31:0] win_len,
                              input logic [15:0] max_fail, input logic [31:0] ban_len);
        write_limit_reg(psl_pkg::CFG_MAX_CONN, {16'd0, max_conn});
        write_limit_reg(psl_pkg::CFG_WINDOW_LEN, win_len);
        write_limit_reg(psl_pkg::CFG_MAX_FAIL, {16'd0, max_fail});
        write_limit_reg(psl_pkg::CFG_BAN_LEN, ban_len);
        i_cfg_we <= 1'b0;
    endtask

    // random traffic: mostly a few hot addresses with a moving clock
    task automatic run_random(input int count, input logic [31:0] scale);
        psl_pkg::t_in r;
        int           p;
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(0, 99);
            if (p < 40)      r.kind = psl_pkg::KIND_CHECK;
            else if (p < 70) r.kind = psl_pkg::KIND_CONN;
            else if (p < 88) r.kind = psl_pkg::KIND_FAIL;
            else             r.kind = psl_pkg::KIND_LOOKUP;
            p = $urandom_range(0, 99);
            if (p < 60)      r.ip_address = key_pool[$urandom_range(0, 7)];
            else if (p < 93) r.ip_address = key_pool[$urandom_range(0, POOL_KEYS - 1)];
            else             r.ip_address = $urandom;
            p = $urandom_range(0, 99);
            if (p < 80)      tick_now = tick_now + $urandom_range(0, scale);
            else if (p < 92) tick_now = tick_now + $urandom_range(0, scale * 8);
            else if (p < 97) tick_now = tick_now + $urandom;
            r.now_time = (p < 97) ? tick_now : $urandom;
            send_req(r, 1'b1, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------- response side

    // response ready with short and long stalls and long ready stretches
    initial begin : rsp_ready_gen
        int n;
        int p;
        n = 1;
        forever begin
            repeat (n) @(posedge i_clk);
            p = $urandom_range(0, 99);
            if (p < 55) begin
                i_rsp_ready <= 1'b1;
                n = $urandom_range(1, 20);
            end else if (p < 65) begin
                i_rsp_ready <= 1'b1;
                n = $urandom_range(50, 200);
            end else if (p < 95) begin
                i_rsp_ready <= 1'b0;
                n = $urandom_range(1, 3);
            end else begin
                i_rsp_ready <= 1'b0;
                n = $urandom_range(10, 60);
            end
        end
    end

    // compare each accepted response with the oldest verdict
    always @(posedge i_clk) begin : rsp_monitor
        psl_pkg::t_out want;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (o_rsp_valid && i_rsp_ready) begin
                if (verdict_q.size() == 0) begin
                    report_error($sformatf("response %0d with nothing outstanding",
                                           rsp_count));
                end else begin
                    want = verdict_q.pop_front();
                    check_field("allowed", 16'(o_rsp.allowed), 16'(want.allowed));
                    check_field("found", 16'(o_rsp.found), 16'(want.found));
                    check_field("banned", 16'(o_rsp.banned), 16'(want.banned));
                    check_field("table_full", 16'(o_rsp.table_full),
                                16'(want.table_full));
                    check_field("connection_count", o_rsp.connection_count,
                                want.connection_count);
                    check_field("failure_count", o_rsp.failure_count,
                                want.failure_count);
                end
                rsp_count++;
            end
        end
    end

    // no handshake on either side for too long
    initial begin : watchdog
        while (quiet_cycles < QUIET_MAX) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial begin : main_seq
        psl_pkg::t_in r;
        logic [31:0]  win_len;
        logic         dup;
        for (int i = 0; i < psl_pkg::TABLE_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            conn_cnt[i]  = '0;
            fail_cnt[i]  = '0;
            win_start[i] = '0;
            ban_until[i] = '0;
        end
        // distinct random addresses, more than the table holds
        for (int i = 0; i < POOL_KEYS; i++) begin
            do begin
                key_pool[i] = $urandom;
                dup = 1'b0;
                for (int j = 0; j < i; j++)
                    if (key_pool[j] == key_pool[i]) dup = 1'b1;
            end while (dup);
        end

        // directed: unknown address, insert, window restart, ban, wrap, lookup
        dir_table.push_back(row(psl_pkg::KIND_CHECK,  32'h0A00_0001, 32'd100, 1'b1,
                                rsp_of(1, 0, 0, 0, 0, 0)));
        dir_table.push_back(row(psl_pkg::KIND_LOOKUP, 32'h0A00_0001, 32'd100, 1'b1,
                                rsp_of(0, 0, 0, 0, 0, 0)));
        dir_table.push_back(row(psl_pkg::KIND_CONN,   32'h0A00_0001, 32'd100, 1'b1,
                                rsp_of(0, 0, 0, 0, 1, 0)));
        dir_table.push_back(row(psl_pkg::KIND_CHECK,  32'h0A00_0001, 32'd200, 1'b1,
                                rsp_of(1, 1, 0, 0, 1, 0)));
        dir_table.push_back(row(psl_pkg::KIND_LOOKUP, 32'h0A00_0001, 32'd200, 1'b1,
                                rsp_of(0, 1, 0, 0, 1, 0)));
        dir_table.push_back(row(psl_pkg::KIND_CHECK,  32'h0A00_0001, 32'd60101, 1'b1,
                                rsp_of(1, 1, 0, 0, 0, 0)));
        dir_table.push_back(row(psl_pkg::KIND_CHECK,  32'h0A00_0001, 32'd120101, 1'b0,
                                '0));
        dir_table.push_back(row(psl_pkg::KIND_FAIL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                rsp_of(0, 0, 0, 0, 0, 1)));
        dir_table.push_back(row(psl_pkg::KIND_FAIL,   32'h0000_0000, 32'd0, 1'b1,
                                rsp_of(0, 0, 0, 0, 0, 1)));
        dir_table.push_back(row(psl_pkg::KIND_FAIL,   32'h0000_0000, 32'd1, 1'b0, '0));
        dir_table.push_back(row(psl_pkg::KIND_FAIL,   32'h0000_0000, 32'd2, 1'b0, '0));
        dir_table.push_back(row(psl_pkg::KIND_FAIL,   32'h0000_0000, 32'd3, 1'b0, '0));
        dir_table.push_back(row(psl_pkg::KIND_FAIL,   32'h0000_0000, 32'd4, 1'b1,
                                rsp_of(0, 1, 1, 0, 0, 5)));
        dir_table.push_back(row(psl_pkg::KIND_CHECK,  32'h0000_0000, 32'd5, 1'b1,
                                rsp_of(0, 1, 1, 0, 0, 5)));
        // ban ends exactly here, window restarts
        dir_table.push_back(row(psl_pkg::KIND_CHECK,  32'h0000_0000, 32'd300004, 1'b0,
                                '0));
        // failure past the limit pushes the ban out again
        dir_table.push_back(row(psl_pkg::KIND_FAIL,   32'h0000_0000, 32'd300010, 1'b0,
                                '0));
        // time wraps between window start and now
        dir_table.push_back(row(psl_pkg::KIND_CONN,   32'hFFFF_FFFF, 32'd0, 1'b0, '0));
        dir_table.push_back(row(psl_pkg::KIND_CHECK,  32'hFFFF_FFFF, 32'd5, 1'b0, '0));
        dir_table.push_back(row(psl_pkg::KIND_CHECK,  32'hFFFF_FFFF, 32'd60006, 1'b0,
                                '0));
        dir_table.push_back(row(psl_pkg::KIND_LOOKUP, 32'h0000_0000, 32'd300011, 1'b0,
                                '0));
        dir_table.push_back(row(psl_pkg::KIND_LOOKUP, 32'h5555_5555, 32'd12345, 1'b1,
                                rsp_of(0, 0, 0, 0, 0, 0)));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i])
            send_req(dir_table[i].req, 1'b1, dir_table[i].exp_given,
                     dir_table[i].exp_rsp);
        drain_verdicts();

        // back to back bursts on two fresh addresses
        tick_now = 32'd400000;
        for (int n = 0; n < SAT_ITEMS; n++) begin
            r.kind       = psl_pkg::KIND_CONN;
            r.ip_address = 32'h0A00_0003;
            r.now_time   = tick_now;
            tick_now     = tick_now + 32'd1;
            send_req(r, 1'b0, 1'b0, '0);
        end
        for (int n = 0; n < SAT_ITEMS; n++) begin
            r.kind       = psl_pkg::KIND_FAIL;
            r.ip_address = 32'h0A00_0004;
            r.now_time   = tick_now;
            tick_now     = tick_now + 32'd1;
            send_req(r, 1'b0, 1'b0, '0);
        end
        drain_verdicts();

        // lowest nonzero limits
        set_limits(16'd1, 32'd1, 16'd1, 32'd1);
        run_random(150, 32'd3);
        drain_verdicts();

        // highest limits
        set_limits(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_random(150, 32'd1 << 20);
        drain_verdicts();

        // zero limits: refuse known addresses unless the window restarts, ban on first failure
        set_limits(16'd0, 32'd1000, 16'd0, 32'd5000);
        run_random(150, 32'd800);
        drain_verdicts();

        // random settings
        for (int ph = 0; ph < 3; ph++) begin
            win_len = $urandom_range(1, 100000);
            set_limits(16'($urandom_range(1, 12)), win_len, 16'($urandom_range(1, 8)),
                       $urandom_range(1, 400000));
            run_random(120, win_len / 3 + 1);
            drain_verdicts();
        end

        // back to the reset values
        set_limits(psl_pkg::CFG_RESET.max_connections, psl_pkg::CFG_RESET.window_length,
                   psl_pkg::CFG_RESET.fail_limit, psl_pkg::CFG_RESET.ban_length);
        run_random(60, 32'd20000);
        drain_verdicts();

        // quiet tail to catch stray responses
        repeat (psl_pkg::TABLE_ENTRIES + 16) @(posedge i_clk);
        if (err_count == 0 && verdict_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/psl_pkg.sv
rtl/core/psl_cell.sv
rtl/core/per_source_connection_limiter_unit.sv
rtl/core/psl_checker.sv
verif/per_source_connection_limiter_unit_test.sv
